/* src/tct_pkg.sv */
// ----------------------------------------------------------------------------
// tct_pkg
// shared types, codes and the power-up category table of the tokenizer
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int LINE_BITS_DEFAULT = 24;
    localparam int LINE_NUM_W        = 24;
    localparam int QUEUE_DEPTH       = 4;

    // input commands
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_END   = 2'd2
    } cmd_t;

    // token kinds
    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_NAME      = 2'd1,
        KIND_PARAGRAPH = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    // category codes
    localparam logic [3:0] CAT_ESCAPE      = 4'd0;
    localparam logic [3:0] CAT_BEGIN_GROUP = 4'd1;
    localparam logic [3:0] CAT_END_GROUP   = 4'd2;
    localparam logic [3:0] CAT_MATH        = 4'd3;
    localparam logic [3:0] CAT_ALIGN       = 4'd4;
    localparam logic [3:0] CAT_NEWLINE     = 4'd5;
    localparam logic [3:0] CAT_PARAMETER   = 4'd6;
    localparam logic [3:0] CAT_SUPER       = 4'd7;
    localparam logic [3:0] CAT_SUB         = 4'd8;
    localparam logic [3:0] CAT_IGNORE      = 4'd9;
    localparam logic [3:0] CAT_SPACE       = 4'd10;
    localparam logic [3:0] CAT_LETTER      = 4'd11;
    localparam logic [3:0] CAT_OTHER       = 4'd12;
    localparam logic [3:0] CAT_ACTIVE      = 4'd13;
    localparam logic [3:0] CAT_COMMENT     = 4'd14;

    // scanner modes
    typedef enum logic [2:0] {
        SM_NORMAL      = 3'd0,
        SM_AFTER_NL    = 3'd1,
        SM_ESCAPE      = 3'd2,
        SM_NAME        = 3'd3,
        SM_SKIP        = 3'd4,
        SM_COMMENT     = 3'd5,
        SM_COMMENT_END = 3'd6,
        SM_NAME_FIRST  = 3'd7
    } scan_mode_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] byte_req;
        logic [3:0] category;
    } src_item_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            char_value;
        logic [3:0]            token_category;
        logic                  name_first;
        logic                  name_last;
        logic [LINE_NUM_W-1:0] line_number;
        logic                  last_of_run;
    } tok_item_t;

    // one token without line number or run mark
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic [3:0] token_category;
        logic       name_first;
        logic       name_last;
    } tok_res_t;

    // queue entry: all tokens of one input beat
    typedef struct packed {
        logic                  two;
        tok_res_t              res0;
        tok_res_t              res1;
        logic [LINE_NUM_W-1:0] line_number;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // power-up contents of the category table
    function automatic logic [3:0] default_category(input logic [7:0] b);
        logic [3:0] c;
        case (b)
            8'h5c:        c = CAT_ESCAPE;
            8'h7b:        c = CAT_BEGIN_GROUP;
            8'h7d:        c = CAT_END_GROUP;
            8'h24:        c = CAT_MATH;
            8'h26:        c = CAT_ALIGN;
            8'h0a:        c = CAT_NEWLINE;
            8'h23:        c = CAT_PARAMETER;
            8'h5e:        c = CAT_SUPER;
            8'h5f:        c = CAT_SUB;
            8'h7f, 8'h0d: c = CAT_IGNORE;
            8'h20, 8'h09: c = CAT_SPACE;
            8'h7e:        c = CAT_ACTIVE;
            8'h25:        c = CAT_COMMENT;
            8'h40:        c = CAT_LETTER;
            default:
            begin
                if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a))
                    c = CAT_LETTER;
                else
                    c = CAT_OTHER;
            end
        endcase
        return c;
    endfunction

endpackage

/* src/tct_stream_if.sv */
// ----------------------------------------------------------------------------
// tct_stream_if
// valid/ready stream channel carrying one payload struct per beat
// ----------------------------------------------------------------------------
interface tct_stream_if #(
    parameter type payload_t = tct_pkg::tok_item_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/tct_front.sv */
// ----------------------------------------------------------------------------
// tct_front
// accepts beats, looks up the category table and runs the scanner state
// ----------------------------------------------------------------------------
module tct_front #(
    parameter int LINE_BITS = tct_pkg::LINE_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tct_stream_if.sink           src,
    input  tct_pkg::q_status_t   qs,
    output logic                 push,
    output tct_pkg::q_entry_t    push_data
);
    localparam logic [7:0] NL_CHAR    = 8'd10;
    localparam int         LINE_EXT_W = (LINE_BITS > tct_pkg::LINE_NUM_W) ?
                                        LINE_BITS : tct_pkg::LINE_NUM_W;

    // category table storage and per-entry written marks
    logic [3:0]   cat_mem [256];
    logic [255:0] cat_set_reg;

    logic                    s1_vld_reg;
    logic [1:0]              s1_cmd_reg;
    logic [7:0]              s1_byte_reg;
    logic [3:0]              rd_cat_reg;
    logic                    rd_set_reg;

    tct_pkg::scan_mode_t     mode_reg, mode_next;
    logic [7:0]              held_reg, held_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic [LINE_EXT_W-1:0]   line_ext;

    logic                    src_acc;
    logic                    s1_go;
    logic                    is_byte, is_end;
    logic [3:0]              cat;
    logic                    is_nl, is_letter;
    logic                    norm_emit, skip_emit, skip_is;
    tct_pkg::scan_mode_t     norm_next, skip_next;
    tct_pkg::tok_res_t       norm_res, res0, res1;
    logic [1:0]              out_cnt;

    function automatic tct_pkg::tok_res_t mk(input logic [1:0] k, input logic [7:0] ch,
                                             input logic [3:0] c, input logic f,
                                             input logic l);
        tct_pkg::tok_res_t r;
        r.kind           = k;
        r.char_value     = ch;
        r.token_category = c;
        r.name_first     = f;
        r.name_last      = l;
        return r;
    endfunction

    assign s1_go     = s1_vld_reg && !qs.full;
    assign src.ready = !s1_vld_reg || s1_go;
    assign src_acc   = src.valid && src.ready;

    // table write and registered lookup
    always_ff @(posedge clk)
    begin
        if (src_acc)
        begin
            if (src.payload.command == tct_pkg::CMD_WRITE)
                cat_mem[src.payload.byte_req] <= src.payload.category;
            rd_cat_reg  <= cat_mem[src.payload.byte_req];
            rd_set_reg  <= cat_set_reg[src.payload.byte_req];
            s1_cmd_reg  <= src.payload.command;
            s1_byte_reg <= src.payload.byte_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cat_set_reg <= '0;
            s1_vld_reg  <= 1'b0;
        end
        else
        begin
            if (src_acc && src.payload.command == tct_pkg::CMD_WRITE)
                cat_set_reg[src.payload.byte_req] <= 1'b1;
            if (src_acc)
                s1_vld_reg <= 1'b1;
            else if (s1_go)
                s1_vld_reg <= 1'b0;
        end
    end

    assign cat       = rd_set_reg ? rd_cat_reg : tct_pkg::default_category(s1_byte_reg);
    assign is_byte   = (s1_cmd_reg == tct_pkg::CMD_BYTE);
    assign is_end    = (s1_cmd_reg == tct_pkg::CMD_END);
    assign is_nl     = (cat == tct_pkg::CAT_NEWLINE);
    assign is_letter = (cat == tct_pkg::CAT_LETTER);

    // plain scanning of one byte, and the variant that swallows blanks
    always_comb
    begin
        norm_emit = !(is_nl || cat == tct_pkg::CAT_ESCAPE || cat == tct_pkg::CAT_IGNORE);
        norm_res  = mk(tct_pkg::KIND_CHAR, s1_byte_reg, cat, 1'b0, 1'b0);
        if (is_nl)
            norm_next = tct_pkg::SM_AFTER_NL;
        else if (cat == tct_pkg::CAT_ESCAPE)
            norm_next = tct_pkg::SM_ESCAPE;
        else if (cat == tct_pkg::CAT_COMMENT)
            norm_next = tct_pkg::SM_COMMENT;
        else if (cat == tct_pkg::CAT_SUPER || cat == tct_pkg::CAT_SUB)
            norm_next = tct_pkg::SM_SKIP;
        else
            norm_next = tct_pkg::SM_NORMAL;
        skip_is   = (cat == tct_pkg::CAT_SPACE) || is_nl;
        skip_emit = !skip_is && norm_emit;
        skip_next = skip_is ? tct_pkg::SM_SKIP : norm_next;
    end

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (is_byte)
        begin
            case (mode_reg)
                tct_pkg::SM_AFTER_NL:
                    mode_next = is_nl ? tct_pkg::SM_NORMAL : norm_next;
                tct_pkg::SM_ESCAPE:
                    mode_next = is_letter ? tct_pkg::SM_NAME_FIRST : tct_pkg::SM_NORMAL;
                tct_pkg::SM_NAME, tct_pkg::SM_NAME_FIRST:
                    mode_next = is_letter ? tct_pkg::SM_NAME : skip_next;
                tct_pkg::SM_SKIP:
                    mode_next = skip_next;
                tct_pkg::SM_COMMENT:
                    mode_next = is_nl ? tct_pkg::SM_COMMENT_END : tct_pkg::SM_COMMENT;
                tct_pkg::SM_COMMENT_END:
                    mode_next = is_nl ? tct_pkg::SM_NORMAL : norm_next;
                default:
                    mode_next = norm_next;
            endcase
        end
        else if (is_end)
            mode_next = tct_pkg::SM_NORMAL;
    end

    // tokens of this beat
    always_comb
    begin
        out_cnt   = 2'd0;
        res0      = '0;
        res1      = '0;
        held_next = held_reg;
        if (is_byte)
        begin
            case (mode_reg)
                tct_pkg::SM_AFTER_NL:
                begin
                    out_cnt = 2'd1;
                    if (is_nl)
                        res0 = mk(tct_pkg::KIND_PARAGRAPH, 8'd0, 4'd0, 1'b0, 1'b0);
                    else
                    begin
                        res0 = mk(tct_pkg::KIND_CHAR, NL_CHAR, tct_pkg::CAT_NEWLINE,
                                  1'b0, 1'b0);
                        res1 = norm_res;
                        if (norm_emit)
                            out_cnt = 2'd2;
                    end
                end
                tct_pkg::SM_ESCAPE:
                begin
                    if (is_letter)
                        held_next = s1_byte_reg;
                    else
                    begin
                        out_cnt = 2'd1;
                        res0    = mk(tct_pkg::KIND_NAME, s1_byte_reg, 4'd0, 1'b1, 1'b1);
                    end
                end
                tct_pkg::SM_NAME, tct_pkg::SM_NAME_FIRST:
                begin
                    out_cnt = 2'd1;
                    res0    = mk(tct_pkg::KIND_NAME, held_reg, 4'd0,
                                 mode_reg == tct_pkg::SM_NAME_FIRST, !is_letter);
                    if (is_letter)
                        held_next = s1_byte_reg;
                    else
                    begin
                        res1 = norm_res;
                        if (skip_emit)
                            out_cnt = 2'd2;
                    end
                end
                tct_pkg::SM_SKIP:
                begin
                    res0 = norm_res;
                    if (skip_emit)
                        out_cnt = 2'd1;
                end
                tct_pkg::SM_COMMENT:
                begin
                    out_cnt = 2'd1;
                    res0    = mk(tct_pkg::KIND_CHAR, s1_byte_reg,
                                 is_nl ? tct_pkg::CAT_NEWLINE : tct_pkg::CAT_LETTER,
                                 1'b0, 1'b0);
                end
                tct_pkg::SM_COMMENT_END:
                begin
                    if (is_nl)
                    begin
                        out_cnt = 2'd1;
                        res0    = mk(tct_pkg::KIND_PARAGRAPH, 8'd0, 4'd0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        res0 = norm_res;
                        if (norm_emit)
                            out_cnt = 2'd1;
                    end
                end
                default:
                begin
                    res0 = norm_res;
                    if (norm_emit)
                        out_cnt = 2'd1;
                end
            endcase
        end
        else if (is_end)
        begin
            case (mode_reg)
                tct_pkg::SM_AFTER_NL:
                begin
                    out_cnt = 2'd1;
                    res0    = mk(tct_pkg::KIND_CHAR, NL_CHAR, tct_pkg::CAT_NEWLINE,
                                 1'b0, 1'b0);
                end
                tct_pkg::SM_ESCAPE:
                begin
                    out_cnt = 2'd1;
                    res0    = mk(tct_pkg::KIND_ERROR, 8'd0, 4'd0, 1'b0, 1'b0);
                end
                tct_pkg::SM_NAME_FIRST:
                begin
                    out_cnt = 2'd1;
                    res0    = mk(tct_pkg::KIND_NAME, held_reg, 4'd0, 1'b1, 1'b1);
                end
                tct_pkg::SM_NAME:
                begin
                    out_cnt = 2'd1;
                    res0    = mk(tct_pkg::KIND_NAME, held_reg, 4'd0, 1'b0, 1'b1);
                end
                default:
                    out_cnt = 2'd0;
            endcase
        end
    end

    // saturating line counter
    always_comb
    begin
        line_next = line_reg;
        if (is_byte && is_nl && line_reg != {LINE_BITS{1'b1}})
            line_next = line_reg + 1'b1;
    end

    assign line_ext = LINE_EXT_W'(line_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tct_pkg::SM_NORMAL;
            held_reg <= 8'd0;
            line_reg <= '0;
        end
        else if (s1_go)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            line_reg <= line_next;
        end
    end

    assign push                  = s1_go && (out_cnt != 2'd0);
    assign push_data.two         = (out_cnt == 2'd2);
    assign push_data.res0        = res0;
    assign push_data.res1        = res1;
    assign push_data.line_number = line_ext[tct_pkg::LINE_NUM_W-1:0];

endmodule

/* src/tct_queue.sv */
// ----------------------------------------------------------------------------
// tct_queue
// short fifo of token groups between scanner and output side
// ----------------------------------------------------------------------------
module tct_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tct_pkg::q_entry_t  push_data,
    input  logic               pop,
    output tct_pkg::q_entry_t  head,
    output tct_pkg::q_status_t qs
);
    localparam int DEPTH = tct_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tct_pkg::q_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign qs.full  = (count_reg == CNT_W'(DEPTH));
    assign qs.empty = (count_reg == '0);
    assign do_push  = push && !qs.full;
    assign do_pop   = pop && !qs.empty;
    assign head     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* src/tct_back.sv */
// ----------------------------------------------------------------------------
// tct_back
// sends the tokens of each queued group one beat at a time
// ----------------------------------------------------------------------------
module tct_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tct_pkg::q_entry_t  head,
    input  tct_pkg::q_status_t qs,
    output logic               pop,
    tct_stream_if.source       tok
);
    logic              sub_reg, sub_next;
    logic              last;
    logic              tok_acc;
    tct_pkg::tok_res_t res;

    assign last      = !head.two || sub_reg;
    assign res       = sub_reg ? head.res1 : head.res0;
    assign tok.valid = !qs.empty;
    assign tok_acc   = tok.valid && tok.ready;
    assign pop       = tok_acc && last;

    assign tok.payload.kind           = res.kind;
    assign tok.payload.char_value     = res.char_value;
    assign tok.payload.token_category = res.token_category;
    assign tok.payload.name_first     = res.name_first;
    assign tok.payload.name_last      = res.name_last;
    assign tok.payload.line_number    = head.line_number;
    assign tok.payload.last_of_run    = last;

    always_comb
    begin
        sub_next = sub_reg;
        if (tok_acc)
            sub_next = !last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 1'b0;
        else
            sub_reg <= sub_next;
    end

endmodule

/* src/tex_category_tokenizer.sv */
// ----------------------------------------------------------------------------
// tex_category_tokenizer
// TeX source tokenizer with writable category table
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                                           per beat
//  -------  ---  -----------------------------------------------  ----------------
//  src      in   command, byte_req, category                      byte/write/end
//  tok      out  kind, char_value, token_category, name_first,    one token
//                name_last, line_number, last_of_run
//
//  one input beat per cycle while the queue is not full; a beat's first token
//  reaches tok through the table read register, then the queue
//  a beat producing two tokens holds the output side for both of its token
//  beats, the four entry queue lets the input side run on meanwhile
//  reset clears scanner mode, held name byte, line count and the table's
//  written marks, so every entry reads its power-up category at once: no
//  clearing pass
//  a full queue stalls the scanner stage, which in turn drops src.ready
//
module tex_category_tokenizer #(
    parameter int LINE_BITS = tct_pkg::LINE_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    tct_stream_if.sink   src,
    tct_stream_if.source tok
);
    // scanner to queue push
    logic               push;
    tct_pkg::q_entry_t  push_data;
    // queue head to output side
    logic               pop;
    tct_pkg::q_entry_t  head;
    tct_pkg::q_status_t qs;

    // front: table lookup, scanner state machine, line counter
    tct_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src),
        .qs        (qs),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue, one entry per input beat with tokens
    tct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qs        (qs)
    );

    // back: splits a group into single token beats
    tct_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qs    (qs),
        .pop   (pop),
        .tok   (tok)
    );

endmodule

/* src/tct_checker.sv */
// ----------------------------------------------------------------------------
// tct_checker
// port-level checks on the token stream, bound to the top level
// ----------------------------------------------------------------------------
module tct_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               tok_valid,
    input logic               tok_ready,
    input tct_pkg::tok_item_t tok_payload
);
    // stalled token holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_payload))
        else $error("token changed while stalled");

    // second token of a pair follows at once, same line, plain character
    a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready && !tok_payload.last_of_run |=>
            tok_valid && tok_payload.kind == tct_pkg::KIND_CHAR &&
            !tok_payload.name_first &&
            tok_payload.line_number == $past(tok_payload.line_number))
        else $error("bad second token of a pair");

    // first of a pair is a pending newline or the end of a name
    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_payload.last_of_run |->
            (tok_payload.kind == tct_pkg::KIND_CHAR && tok_payload.char_value == 8'd10 &&
             tok_payload.token_category == tct_pkg::CAT_NEWLINE) ||
            (tok_payload.kind == tct_pkg::KIND_NAME && tok_payload.name_last))
        else $error("bad first token of a pair");

endmodule

bind tex_category_tokenizer tct_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (tok.valid),
    .tok_ready   (tok.ready),
    .tok_payload (tok.payload)
);

/* tb/tex_category_tokenizer_tb.sv */
// ----------------------------------------------------------------------------
// tex_category_tokenizer_tb
// self-checking bench for the TeX source tokenizer: a short directed table
// walks the power-up categories, names, comments, paragraphs, table writes
// and end-of-input flushing, then random TeX-like text with table rewrites
// runs under random idling on both channels; every token is compared with its
// typed row's token or with a bit-accurate scanner kept inside the bench
// ----------------------------------------------------------------------------
module tex_category_tokenizer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tct_pkg::*;

    // run shape
    localparam int RANDOM_BEATS = 1500;
    localparam int IDLE_PCT     = 38;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 600;     // receiver cycle where the long hold-off starts
    localparam int HOLD_LEN     = 100;
    localparam int RX_STEADY_LO = 1500;    // receiver always ready in this window
    localparam int RX_STEADY_HI = 2100;
    localparam int TX_STEADY_LO = 500;     // sender never idles for these random beats
    localparam int TX_STEADY_HI = 800;

    // command value with no meaning, the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // characters used by the stimulus
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_ESC    = 8'h5c;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_TILDE  = 8'h7e;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] PUNCT [8] = '{8'h7b, 8'h7d, 8'h24, 8'h26, 8'h23, 8'h7e, 8'h30, 8'h2e};

    // one row of the directed table; typed rows carry their single token
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] byte_in;
        logic [3:0] cat_in;
        logic       typed;
        kind_t      kind;
        logic [7:0] char_out;
        logic [3:0] cat_out;
    } step_row_t;

    localparam int PLAN_LEN = 32;

    // rows marked typed sit right after reset, so their line number is zero
    step_row_t plan [PLAN_LEN] = '{
        '{CMD_BYTE,   8'h61,     4'd0,  1'b1, KIND_CHAR,  8'h61, CAT_LETTER}, // plain letter
        '{CMD_BYTE,   8'h00,     4'd15, 1'b1, KIND_CHAR,  8'h00, CAT_OTHER},  // lowest byte
        '{CMD_BYTE,   8'hff,     4'd0,  1'b1, KIND_CHAR,  8'hff, CAT_OTHER},  // highest byte
        '{CMD_UNUSED, 8'hff,     4'd15, 1'b0, KIND_CHAR,  8'h00, 4'd0},       // ignored command
        '{CMD_BYTE,   CH_ESC,    4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_END,    8'h00,     4'd0,  1'b1, KIND_ERROR, 8'h00, 4'd0},       // escape at end
        '{CMD_BYTE,   CH_ESC,    4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // letter name
        '{CMD_BYTE,   8'h61,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   8'h62,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   CH_NL,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // dropped newline
        '{CMD_BYTE,   CH_CARET,  4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // superscript skip
        '{CMD_BYTE,   CH_TILDE,  4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   CH_NL,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   8'h79,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // two tokens
        '{CMD_BYTE,   CH_NL,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   CH_NL,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // blank line
        '{CMD_BYTE,   CH_PCT,    4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // comment
        '{CMD_BYTE,   CH_LBRACE, 4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   CH_NL,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   CH_NL,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // par after comment
        '{CMD_WRITE,  8'h71,     CAT_IGNORE, 1'b0, KIND_CHAR, 8'h00, 4'd0},
        '{CMD_BYTE,   8'h71,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // now vanishes
        '{CMD_WRITE,  8'h71,     CAT_LETTER, 1'b0, KIND_CHAR, 8'h00, 4'd0},
        '{CMD_BYTE,   CH_ESC,    4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // one-byte name
        '{CMD_BYTE,   CH_LBRACE, 4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   CH_ESC,    4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_BYTE,   8'h7a,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_END,    8'h00,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // flush held name
        '{CMD_BYTE,   CH_NL,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_END,    8'h00,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},       // flush newline
        '{CMD_BYTE,   CH_PCT,    4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0},
        '{CMD_END,    8'h00,     4'd0,  1'b0, KIND_CHAR,  8'h00, 4'd0}        // end inside comment
    };

    logic clk;
    logic rst_n;

    tct_stream_if #(.payload_t(src_item_t)) src_if ();
    tct_stream_if #(.payload_t(tok_item_t)) tok_if ();

    tex_category_tokenizer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_if),
        .tok   (tok_if)
    );

    // ------------------------------------------------------------------
    // scanner state mirrored in the bench
    // ------------------------------------------------------------------
    logic [3:0]            boot_map [256];   // power-up categories
    logic [3:0]            cat_map  [256];   // live categories
    scan_mode_t            scan_st;
    logic [7:0]            held_byte;
    logic [LINE_NUM_W-1:0] line_cnt;

    tok_item_t  beat_toks [$];    // tokens caused by the beat being scanned
    tok_item_t  tokens_due [$];   // tokens still to come out of the block
    src_item_t  beats_todo [$];   // random beats waiting to be sent
    logic [7:0] rewritten [$];    // table entries moved off their default

    int  mismatches;
    int  cycle_count;
    int  rx_cycle;
    bit  tx_steady;

    // ------------------------------------------------------------------
    // clock, reset, run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void load_boot_map();
        for (int i = 0; i < 256; i++)
        begin
            if ((i >= 8'h61 && i <= 8'h7a) || (i >= 8'h41 && i <= 8'h5a) || i == 8'h40)
                boot_map[i] = CAT_LETTER;
            else
                boot_map[i] = CAT_OTHER;
        end
        boot_map[CH_ESC]    = CAT_ESCAPE;
        boot_map[8'h7b]     = CAT_BEGIN_GROUP;
        boot_map[8'h7d]     = CAT_END_GROUP;
        boot_map[8'h24]     = CAT_MATH;
        boot_map[8'h26]     = CAT_ALIGN;
        boot_map[CH_NL]     = CAT_NEWLINE;
        boot_map[8'h23]     = CAT_PARAMETER;
        boot_map[CH_CARET]  = CAT_SUPER;
        boot_map[CH_UNDER]  = CAT_SUB;
        boot_map[CH_DEL]    = CAT_IGNORE;
        boot_map[CH_CR]     = CAT_IGNORE;
        boot_map[CH_SP]     = CAT_SPACE;
        boot_map[CH_TAB]    = CAT_SPACE;
        boot_map[CH_TILDE]  = CAT_ACTIVE;
        boot_map[CH_PCT]    = CAT_COMMENT;
        cat_map   = boot_map;
        scan_st   = SM_NORMAL;
        held_byte = '0;
        line_cnt  = '0;
    endfunction

    function automatic void add_tok(kind_t k, logic [7:0] ch, logic [3:0] cat,
                                    logic first, logic last);
        tok_item_t t;
        t                = '0;
        t.kind           = k;
        t.char_value     = ch;
        t.token_category = cat;
        t.name_first     = first;
        t.name_last      = last;
        beat_toks = {beat_toks, t};
    endfunction

    // a byte seen in the normal state
    function automatic void scan_plain(logic [7:0] b);
        logic [3:0] c;
        c       = cat_map[b];
        scan_st = SM_NORMAL;
        if (c == CAT_NEWLINE)
            scan_st = SM_AFTER_NL;
        else if (c == CAT_ESCAPE)
            scan_st = SM_ESCAPE;
        else if (c != CAT_IGNORE)
        begin
            add_tok(KIND_CHAR, b, c, 1'b0, 1'b0);
            if (c == CAT_COMMENT)
                scan_st = SM_COMMENT;
            else if (c == CAT_SUPER || c == CAT_SUB)
                scan_st = SM_SKIP;
        end
    endfunction

    // blanks keep being swallowed, anything else scans normally
    function automatic void scan_skipping(logic [7:0] b);
        if (cat_map[b] == CAT_SPACE || cat_map[b] == CAT_NEWLINE)
            scan_st = SM_SKIP;
        else
            scan_plain(b);
    endfunction

    // fills beat_toks with the tokens of one beat and advances the state
    function automatic void tokenize_beat(src_item_t beat);
        logic [7:0] b;
        logic [3:0] c;
        logic       first;
        b = beat.byte_req;
        c = cat_map[b];
        beat_toks.delete();
        case (beat.command)
            CMD_WRITE:
            begin
                cat_map[b] = beat.category;
            end
            CMD_BYTE:
            begin
                // every newline-class byte counts, dropped ones too
                if (c == CAT_NEWLINE && line_cnt != {LINE_NUM_W{1'b1}})
                    line_cnt = line_cnt + 1'b1;
                case (scan_st)
                    SM_AFTER_NL:
                    begin
                        if (c == CAT_NEWLINE)
                        begin
                            add_tok(KIND_PARAGRAPH, 8'h00, 4'd0, 1'b0, 1'b0);
                            scan_st = SM_NORMAL;
                        end
                        else
                        begin
                            add_tok(KIND_CHAR, CH_NL, CAT_NEWLINE, 1'b0, 1'b0);
                            scan_plain(b);
                        end
                    end
                    SM_ESCAPE:
                    begin
                        if (c == CAT_LETTER)
                        begin
                            held_byte = b;
                            scan_st   = SM_NAME_FIRST;
                        end
                        else
                        begin
                            add_tok(KIND_NAME, b, 4'd0, 1'b1, 1'b1);
                            scan_st = SM_NORMAL;
                        end
                    end
                    SM_NAME_FIRST, SM_NAME:
                    begin
                        // name bytes go out one behind, so the last one can be marked
                        first = (scan_st == SM_NAME_FIRST);
                        if (c == CAT_LETTER)
                        begin
                            add_tok(KIND_NAME, held_byte, 4'd0, first, 1'b0);
                            held_byte = b;
                            scan_st   = SM_NAME;
                        end
                        else
                        begin
                            add_tok(KIND_NAME, held_byte, 4'd0, first, 1'b1);
                            scan_skipping(b);
                        end
                    end
                    SM_SKIP:
                    begin
                        scan_skipping(b);
                    end
                    SM_COMMENT:
                    begin
                        if (c == CAT_NEWLINE)
                        begin
                            add_tok(KIND_CHAR, b, CAT_NEWLINE, 1'b0, 1'b0);
                            scan_st = SM_COMMENT_END;
                        end
                        else
                            add_tok(KIND_CHAR, b, CAT_LETTER, 1'b0, 1'b0);
                    end
                    SM_COMMENT_END:
                    begin
                        if (c == CAT_NEWLINE)
                        begin
                            add_tok(KIND_PARAGRAPH, 8'h00, 4'd0, 1'b0, 1'b0);
                            scan_st = SM_NORMAL;
                        end
                        else
                            scan_plain(b);
                    end
                    default:
                    begin
                        scan_plain(b);
                    end
                endcase
            end
            CMD_END:
            begin
                case (scan_st)
                    SM_AFTER_NL:   add_tok(KIND_CHAR, CH_NL, CAT_NEWLINE, 1'b0, 1'b0);
                    SM_ESCAPE:     add_tok(KIND_ERROR, 8'h00, 4'd0, 1'b0, 1'b0);
                    SM_NAME_FIRST: add_tok(KIND_NAME, held_byte, 4'd0, 1'b1, 1'b1);
                    SM_NAME:       add_tok(KIND_NAME, held_byte, 4'd0, 1'b0, 1'b1);
                    default:
                    begin
                    end
                endcase
                scan_st = SM_NORMAL;
            end
            default:
            begin
            end
        endcase
        foreach (beat_toks[k])
        begin
            beat_toks[k].line_number = line_cnt;
            beat_toks[k].last_of_run = (k == beat_toks.size() - 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // random text generation, in whole TeX-like pieces
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'h61 + r[7:0];
        else if (r < 52)
            return 8'h41 + r[7:0] - 8'd26;
        return 8'h40;
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        // the category field is ignored on byte beats, so it stays random
        beats_todo = {beats_todo, src_item_t'{CMD_BYTE, b, 4'($urandom_range(0, 15))}};
    endfunction

    function automatic void queue_blanks(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 3);
            queue_byte(r == 0 ? CH_NL : (r == 1 ? CH_TAB : CH_SP));
        end
    endfunction

    function automatic void queue_piece();
        int         pick;
        int         r;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 24)
        begin
            // word and a blank
            repeat ($urandom_range(1, 6)) queue_byte(pick_letter());
            queue_blanks(1);
        end
        else if (pick < 44)
        begin
            // control word with trailing blanks
            queue_byte(CH_ESC);
            repeat ($urandom_range(1, 5)) queue_byte(pick_letter());
            queue_blanks($urandom_range(0, 2));
        end
        else if (pick < 51)
        begin
            // control symbol of any byte
            queue_byte(CH_ESC);
            queue_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 59)
        begin
            // comment with a mixed body, sometimes a blank line after it
            queue_byte(CH_PCT);
            repeat ($urandom_range(0, 5))
                queue_byte($urandom_range(0, 1) ? pick_letter() : 8'($urandom_range(0, 255)));
            queue_byte(CH_NL);
            if ($urandom_range(0, 1))
                queue_byte(CH_NL);
        end
        else if (pick < 67)
        begin
            repeat ($urandom_range(1, 3)) queue_byte(CH_NL);
        end
        else if (pick < 73)
        begin
            queue_byte($urandom_range(0, 1) ? CH_CARET : CH_UNDER);
            queue_blanks($urandom_range(0, 2));
            queue_byte(pick_letter());
        end
        else if (pick < 81)
        begin
            queue_byte(PUNCT[$urandom_range(0, 7)]);
        end
        else if (pick < 89)
        begin
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 93)
        begin
            // table rewrite, or put a rewritten entry back to its default
            if (rewritten.size() != 0 && $urandom_range(0, 1))
            begin
                idx = rewritten.pop_front();
                beats_todo = {beats_todo, src_item_t'{CMD_WRITE, idx, boot_map[idx]}};
            end
            else
            begin
                r = $urandom_range(0, 3);
                idx = (r == 0) ? pick_letter() : (r == 1) ? CH_NL :
                      (r == 2) ? CH_ESC : 8'($urandom_range(0, 255));
                beats_todo = {beats_todo,
                              src_item_t'{CMD_WRITE, idx, 4'($urandom_range(0, 15))}};
                rewritten = {rewritten, idx};
            end
        end
        else if (pick < 97)
        begin
            // end of input, sometimes with a lone escape or a pending name
            r = $urandom_range(0, 2);
            if (r != 2)
                queue_byte(CH_ESC);
            if (r == 1)
                queue_byte(pick_letter());
            beats_todo = {beats_todo, src_item_t'{CMD_END, 8'($urandom_range(0, 255)),
                                                  4'($urandom_range(0, 15))}};
        end
        else if (pick < 99)
        begin
            beats_todo = {beats_todo, src_item_t'{CMD_UNUSED, 8'($urandom_range(0, 255)),
                                                  4'($urandom_range(0, 15))}};
        end
        else
        begin
            queue_byte($urandom_range(0, 1) ? CH_CR : CH_DEL);
        end
    endfunction

    // ------------------------------------------------------------------
    // sender: idles at random, then holds the beat until it is taken
    // ------------------------------------------------------------------
    task automatic send_beat(input src_item_t beat);
        while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            src_if.valid <= 1'b0;
            @(posedge clk);
        end
        src_if.valid   <= 1'b1;
        src_if.payload <= beat;
        do
            @(posedge clk);
        while (!src_if.ready);
    endtask

    function automatic void await_tokens();
        foreach (beat_toks[k])
            tokens_due = {tokens_due, beat_toks[k]};
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold-off that fills the block's
    // queue and backs up the input, and a stretch of steady acceptance
    // ------------------------------------------------------------------
    initial
    begin
        rx_cycle = 0;
        tok_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle == HOLD_AT)
            begin
                tok_if.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                rx_cycle += HOLD_LEN;
            end
            tok_if.ready <= (rx_cycle >= RX_STEADY_LO && rx_cycle < RX_STEADY_HI) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // token checker
    // ------------------------------------------------------------------
    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    tok_item_t due_tok;
    tok_item_t got_tok;

    always @(posedge clk)
    begin
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            got_tok = tok_if.payload;
            if (tokens_due.size() == 0)
            begin
                $error("token with none due: kind %0d char 0x%02h", got_tok.kind,
                       got_tok.char_value);
                mismatches++;
            end
            else
            begin
                due_tok = tokens_due.pop_front();
                check_field("kind", due_tok.kind, got_tok.kind);
                check_field("char_value", due_tok.char_value, got_tok.char_value);
                check_field("token_category", due_tok.token_category, got_tok.token_category);
                check_field("name_first", due_tok.name_first, got_tok.name_first);
                check_field("name_last", due_tok.name_last, got_tok.name_last);
                check_field("line_number", due_tok.line_number, got_tok.line_number);
                check_field("last_of_run", due_tok.last_of_run, got_tok.last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        src_item_t beat;
        tok_item_t typed_tok;
        int        sent;

        mismatches  = 0;
        cycle_count = 0;
        tx_steady   = 1'b0;
        load_boot_map();
        rst_n          <= 1'b0;
        src_if.valid   <= 1'b0;
        src_if.payload <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; typed rows still run through the scanner so its
        // state keeps step, but the hand-written token is what gets checked
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            beat = src_item_t'{plan[i].cmd, plan[i].byte_in, plan[i].cat_in};
            send_beat(beat);
            tokenize_beat(beat);
            if (plan[i].typed)
            begin
                typed_tok                = '0;
                typed_tok.kind           = plan[i].kind;
                typed_tok.char_value     = plan[i].char_out;
                typed_tok.token_category = plan[i].cat_out;
                typed_tok.last_of_run    = 1'b1;
                tokens_due = {tokens_due, typed_tok};
            end
            else
                await_tokens();
        end

        // random text; ignored commands do not count toward the total
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            if (beats_todo.size() == 0)
                queue_piece();
            beat      = beats_todo.pop_front();
            tx_steady = (sent >= TX_STEADY_LO && sent < TX_STEADY_HI);
            send_beat(beat);
            tokenize_beat(beat);
            await_tokens();
            if (beat.command != CMD_UNUSED)
                sent++;
        end
        src_if.valid <= 1'b0;

        // drain, then give stray tokens a chance to show up
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* tex_category_tokenizer.f */
src/tct_pkg.sv
src/tct_stream_if.sv
src/tct_front.sv
src/tct_queue.sv
src/tct_back.sv
src/tex_category_tokenizer.sv
src/tct_checker.sv
tb/tex_category_tokenizer_tb.sv
